// File: rtl/crc32_packet_framer_core_macros.svh
// Assertion macros for the CRC-32 packet framer.
// Taken in by the top level; no other dependencies.
`ifndef CRC32_PACKET_FRAMER_CORE_MACROS_SVH
`define CRC32_PACKET_FRAMER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CPF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("framer assertion failed");
`define CPF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("framer assertion failed");
`else
`define CPF_ASSERT(label, clk, rst, prop)
`define CPF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/cpf_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the packet framer.
// No dependencies.
package cpf_pkg;
   localparam logic        FUNC_START       = 1'b0;
   localparam logic        FUNC_DATA        = 1'b1;
   localparam logic        CSR_FRAME_HEADER = 1'b0;
   localparam logic        CSR_END_MARKER   = 1'b1;
   localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
   localparam logic [7:0]  END_MARKER_RST   = 8'hB2;
   localparam logic [7:0]  EMPTY_LEN_CODE   = 8'hFF;
   localparam logic [2:0]  TRAILER_LAST     = 3'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } cpf_word_type;

   typedef struct packed {
      logic       item_vld;
      logic       trailer;
      logic [2:0] step;
      logic       in_frame;
   } cpf_status_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction
endpackage

// File: rtl/cpf_seq.sv
// Input word register and byte sequencer with running CRC-32.
// Depends on cpf_pkg.
module cpf_seq
   import cpf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  logic [23:0]    req_tdata,
   input  logic [7:0]     frame_header,
   input  logic [7:0]     end_marker,
   input  logic           out_free,
   output logic           emit,
   output cpf_word_type   word,
   output cpf_status_type status
);
   logic        item_vld_ff, item_vld_in;
   logic        item_func_ff;
   logic [7:0]  item_cmd_ff, item_len_ff, item_data_ff;
   logic        trailer_ff, trailer_in;
   logic [2:0]  step_ff, step_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic        in_frame_ff, in_frame_in;

   logic        is_start, drop, last_data, need_tr, done, load;
   logic [31:0] crc_base, crc_inv;
   logic [7:0]  len_byte, data_byte_sel, trailer_byte;

   always_comb begin
      is_start = item_func_ff == FUNC_START;
      drop     = item_vld_ff && !is_start && !in_frame_ff && !trailer_ff;
      emit     = item_vld_ff && !drop && out_free;
      crc_base = (is_start && !trailer_ff && step_ff == 3'd0) ? CRC_INIT : crc_ff;
      crc_inv  = ~crc_ff;
      len_byte = (item_len_ff == 8'd0) ? EMPTY_LEN_CODE : item_len_ff;
      last_data = is_start ? (step_ff == 3'd2) : (step_ff == 3'd0);
      need_tr   = is_start ? (item_len_ff == 8'd0) : (bytes_left_ff == 8'd1);

      case (step_ff)
         3'd0:    data_byte_sel = is_start ? frame_header : item_data_ff;
         3'd1:    data_byte_sel = item_cmd_ff;
         3'd2:    data_byte_sel = len_byte;
         default: data_byte_sel = item_data_ff;
      endcase

      case (step_ff)
         3'd0:    trailer_byte = end_marker;
         3'd1:    trailer_byte = crc_inv[7:0];
         3'd2:    trailer_byte = crc_inv[15:8];
         3'd3:    trailer_byte = crc_inv[23:16];
         3'd4:    trailer_byte = crc_inv[31:24];
         default: trailer_byte = end_marker;
      endcase

      word.out_byte = trailer_ff ? trailer_byte : data_byte_sel;
      word.last     = trailer_ff && step_ff == TRAILER_LAST;

      done = drop || (emit && (trailer_ff ? step_ff == TRAILER_LAST
                                          : (last_data && !need_tr)));
      req_tready = !item_vld_ff || done;
      load       = req_tvalid && req_tready;

      item_vld_in   = load ? 1'b1 : (done ? 1'b0 : item_vld_ff);
      trailer_in    = trailer_ff;
      step_in       = step_ff;
      crc_in        = crc_ff;
      bytes_left_in = bytes_left_ff;
      in_frame_in   = in_frame_ff;

      if (emit) begin
         if (!trailer_ff) begin
            crc_in = crc_byte(crc_base, data_byte_sel);
            if (!is_start) begin
               bytes_left_in = bytes_left_ff - 8'd1;
            end
            if (last_data) begin
               step_in    = 3'd0;
               trailer_in = need_tr;
               if (is_start && !need_tr) begin
                  in_frame_in   = 1'b1;
                  bytes_left_in = item_len_ff;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end else if (step_ff == TRAILER_LAST) begin
            trailer_in    = 1'b0;
            step_in       = 3'd0;
            crc_in        = CRC_INIT;
            in_frame_in   = 1'b0;
            bytes_left_in = 8'd0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end

      status.item_vld = item_vld_ff;
      status.trailer  = trailer_ff;
      status.step     = step_ff;
      status.in_frame = in_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff   <= 1'b0;
         trailer_ff    <= 1'b0;
         step_ff       <= 3'd0;
         crc_ff        <= CRC_INIT;
         bytes_left_ff <= 8'd0;
         in_frame_ff   <= 1'b0;
      end else begin
         item_vld_ff   <= item_vld_in;
         trailer_ff    <= trailer_in;
         step_ff       <= step_in;
         crc_ff        <= crc_in;
         bytes_left_ff <= bytes_left_in;
         in_frame_ff   <= in_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_func_ff <= req_tuser;
         item_cmd_ff  <= req_tdata[7:0];
         item_len_ff  <= req_tdata[15:8];
         item_data_ff <= req_tdata[23:16];
      end
   end
endmodule

// File: rtl/cpf_out_reg.sv
// Output word register between the sequencer and the result channel.
// Depends on cpf_pkg.
module cpf_out_reg
   import cpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_vld,
   input  cpf_word_type word,
   output logic         out_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);
   logic         vld_ff, vld_in;
   cpf_word_type word_ff;

   always_comb begin
      out_free   = !vld_ff || rsp_tready;
      vld_in     = out_free ? in_vld : vld_ff;
      rsp_tvalid = vld_ff;
      rsp_tdata  = word_ff.out_byte;
      rsp_tlast  = word_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_vld) begin
         word_ff <= word;
      end
   end
endmodule

// File: rtl/crc32_packet_framer_core.sv
// Channel  Dir  Word fields (low bit up)
// req      in   tuser: func; tdata: command, payload_length, data_byte
// rsp      out  tdata: out_byte; tlast: last
// csr      in   write only: index 0 frame_header, 1 end_marker
// An in-frame payload word gives one byte a cycle; a start word gives 3 bytes, or 8 when
// empty, and the last payload word 6 bytes, one per cycle while rsp does not stall, set
// by the single byte-wide CRC step. Results pass the item and output registers.
// Synchronous reset clears the sequencer and the frame state and presets the CRC to all ones.
// rsp stalls back-pressure req; one req word is held while the result register is full.
`include "crc32_packet_framer_core_macros.svh"
module crc32_packet_framer_core
   import cpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [23:0] req_tdata,   // command, payload_length, data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   logic [7:0]     frame_header_ff, end_marker_ff;
   logic           out_free, emit;
   cpf_word_type   word;
   cpf_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_header_ff <= 8'd0;
         end_marker_ff   <= END_MARKER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_HEADER: frame_header_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default:          frame_header_ff <= frame_header_ff;
         endcase
      end
   end

   cpf_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .frame_header (frame_header_ff),
      .end_marker   (end_marker_ff),
      .out_free     (out_free),
      .emit         (emit),
      .word         (word),
      .status       (status)
   );

   cpf_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (emit),
      .word       (word),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `CPF_ASSERT(a_step_range, clock, reset, status.step <= TRAILER_LAST)
   `CPF_ASSERT(a_trailer_has_item, clock, reset, status.trailer |-> status.item_vld)
   `CPF_ASSERT(a_busy_has_item, clock, reset, !req_tready |-> status.item_vld)
   `CPF_ASSERT(a_emit_space, clock, reset, emit |-> out_free)
endmodule
